// ----- hdl/bdi_pkg.sv -----
// Package for the book depth imbalance block: defaults, request codes and
// sequencer states. No dependencies.
`default_nettype none
package bdi_pkg;
  localparam int MAX_LEVELS_DEF = 32;
  localparam int MAX_BINS_DEF   = 16;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_BID     = 2'd0,
    REQ_ASK     = 2'd1,
    REQ_BIN     = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_type_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_LIM,
    ST_WALK,
    ST_DIV_A,
    ST_IMB,
    ST_WMUL,
    ST_DIV_B,
    ST_WSAT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/bdi_channels.sv -----
// Valid/ready channel interfaces for the book depth imbalance block:
// request words, result words and the configuration write. No dependencies.
`default_nettype none
interface bdi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  entry_index;
  logic [23:0] level_price;
  logic [23:0] level_size;
  logic [15:0] bin_multiplier;
  logic [5:0]  bid_level_count;
  logic [5:0]  ask_level_count;
  logic [31:0] mid_price;
  logic [23:0] median_spread;
  logic [31:0] day_volume;
  modport source (output valid, req_type, entry_index, level_price, level_size,
                  bin_multiplier, bid_level_count, ask_level_count, mid_price,
                  median_spread, day_volume, input ready);
  modport sink (input valid, req_type, entry_index, level_price, level_size,
                bin_multiplier, bid_level_count, ask_level_count, mid_price,
                median_spread, day_volume, output ready);
endinterface

interface bdi_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         bin_number;
  logic signed [15:0] imbalance;
  logic signed [31:0] weighted_imbalance;
  logic               imbalance_valid;
  logic               weighted_valid;
  logic               last_of_run;
  modport source (output valid, bin_number, imbalance, weighted_imbalance,
                  imbalance_valid, weighted_valid, last_of_run, input ready);
  modport sink (input valid, bin_number, imbalance, weighted_imbalance,
                imbalance_valid, weighted_valid, last_of_run, output ready);
endinterface

interface bdi_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] bins_in_use;
  modport source (output valid, bins_in_use, input ready);
  modport sink (input valid, bins_in_use, output ready);
endinterface
`default_nettype wire

// ----- hdl/book_depth_imbalance.sv -----
// Book depth imbalance top level: level and bin stores, band walk and a
// shared restoring divider under one sequencer. Uses bdi_pkg, bdi_channels.
//
// Usage:
//   req: write words (bid level, ask level, bin multiplier) give no result.
//     A compute word starts a run of bins_in_use results, capped at MAX_BINS
//     (none when zero), one per band, last_of_run on the final one.
//   cfg: writes bins_in_use; always ready, write only while idle.
//   res: one registered result word per band; it holds until taken, and the
//     sequencer waits there while the receiver stalls.
// Per band: setup (multiply, then limits), then a walk over the levels (both
//   sides in parallel). A zero total goes straight to the result state.
//   Otherwise one divider pass, and when day_volume is nonzero a multiply and
//   load state, a second divider pass and a saturate state, then the result
//   state.
// req is not ready while a compute run is in progress.
// Reset (rst, synchronous) clears the sequencer and bins_in_use; the stores
//   hold nothing defined until written.
`default_nettype none
module book_depth_imbalance #(
  parameter int MAX_LEVELS = bdi_pkg::MAX_LEVELS_DEF,
  parameter int MAX_BINS   = bdi_pkg::MAX_BINS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bdi_req_if.sink   req,
  bdi_res_if.source res,
  bdi_cfg_if.sink   cfg
);
  import bdi_pkg::*;

  localparam int AW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW   = $clog2(MAX_LEVELS + 1);
  localparam int BW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BCW  = $clog2(MAX_BINS + 1);
  localparam int SW   = 24 + CW;
  localparam int DW   = (SW > 32) ? SW : 32;
  localparam int DVW  = SW + 18;
  localparam int DCW  = $clog2(DVW);

  state_t state, state_next;

  // stores
  logic [23:0] bid_price_mem [MAX_LEVELS];
  logic [23:0] bid_size_mem  [MAX_LEVELS];
  logic [23:0] ask_price_mem [MAX_LEVELS];
  logic [23:0] ask_size_mem  [MAX_LEVELS];
  logic [15:0] bin_mem       [MAX_BINS];
  logic [23:0] bid_price_rd, bid_size_rd, ask_price_rd, ask_size_rd;
  logic [15:0] bin_rd;

  logic [4:0]  bins_in_use;
  logic [31:0] mid;
  logic [23:0] spread;
  logic [31:0] vol;
  logic [CW-1:0]  nbid, nask, bl, al, bl_next, al_next;
  logic [BCW-1:0] nbins, bin, bin_next;
  logic [SW-1:0]  tb, ta;
  logic [39:0]    hw;
  logic signed [41:0] blim, alim;
  logic signed [15:0] imb;
  logic [SW+15:0] prod;

  // divider
  logic [DVW-1:0] dq;
  logic [DW-1:0]  dvs, rem;
  logic [DCW-1:0] dcnt;
  logic [DW:0]    dtrial;
  logic           dfit;

  logic accept, accept_cmp, res_take, bid_go, ask_go, sum_zero, last_bin;
  logic [SW-1:0] tsum, tdiff;
  logic [8:0]    idx_ext;
  logic [DVW-1:0] q_abs;

  assign accept     = req.valid && req.ready;
  assign accept_cmp = accept && (req.req_type == REQ_COMPUTE);
  assign res_take   = res.valid && res.ready;
  assign idx_ext    = {4'd0, req.entry_index};
  assign cfg.ready  = 1'b1;

  assign bid_go = (bl < nbid) &&
                  ($signed({2'b00, bid_price_rd, 16'd0}) >= blim);
  assign ask_go = (al < nask) &&
                  ($signed({2'b00, ask_price_rd, 16'd0}) <= alim);
  assign tsum     = tb + ta;
  assign tdiff    = (tb >= ta) ? (tb - ta) : (ta - tb);
  assign sum_zero = (tsum == '0);
  assign last_bin = (bin + BCW'(1)) == nbins;
  assign dtrial   = {rem, dq[DVW-1]};
  assign dfit     = dtrial >= {1'b0, dvs};
  assign q_abs    = dq;

  // |imbalance| times the larger side
  assign prod = (SW+16)'($unsigned(imb[15] ? -imb : imb)) *
                (SW+16)'((tb > ta) ? tb : ta);

  // next read addresses, so read data always matches the current pointer
  always_comb begin
    bl_next  = bl;
    al_next  = al;
    bin_next = bin;
    if (state == ST_IDLE && accept_cmp) begin
      bl_next  = '0;
      al_next  = '0;
      bin_next = '0;
    end else if (state == ST_WALK) begin
      if (bid_go) bl_next = bl + CW'(1);
      if (ask_go) al_next = al + CW'(1);
    end else if (state == ST_OUT && res_take) begin
      bin_next = bin + BCW'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_cmp && req.req_type == REQ_COMPUTE && bins_in_use != 5'd0)
          state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_LIM;
      ST_LIM:  state_next = ST_WALK;
      ST_WALK: begin
        if (!bid_go && !ask_go) state_next = sum_zero ? ST_OUT : ST_DIV_A;
      end
      ST_DIV_A: if (dcnt == DCW'(DVW - 1)) state_next = ST_IMB;
      ST_IMB:   state_next = (vol == 32'd0) ? ST_OUT : ST_WMUL;
      ST_WMUL:  state_next = ST_DIV_B;
      ST_DIV_B: if (dcnt == DCW'(DVW - 1)) state_next = ST_WSAT;
      ST_WSAT:  state_next = ST_OUT;
      ST_OUT: begin
        if (res_take) state_next = last_bin ? ST_IDLE : ST_MUL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    res.valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) bins_in_use <= 5'd0;
    else if (cfg.valid && cfg.ready) bins_in_use <= cfg.bins_in_use;
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (accept && idx_ext < 9'(MAX_LEVELS)) begin
      if (req.req_type == REQ_BID) begin
        bid_price_mem[idx_ext[AW-1:0]] <= req.level_price;
        bid_size_mem[idx_ext[AW-1:0]]  <= req.level_size;
      end
      if (req.req_type == REQ_ASK) begin
        ask_price_mem[idx_ext[AW-1:0]] <= req.level_price;
        ask_size_mem[idx_ext[AW-1:0]]  <= req.level_size;
      end
    end
    if (accept && req.req_type == REQ_BIN && idx_ext < 9'(MAX_BINS))
      bin_mem[idx_ext[BW-1:0]] <= req.bin_multiplier;
    bid_price_rd <= bid_price_mem[bl_next[AW-1:0]];
    bid_size_rd  <= bid_size_mem[bl_next[AW-1:0]];
    ask_price_rd <= ask_price_mem[al_next[AW-1:0]];
    ask_size_rd  <= ask_size_mem[al_next[AW-1:0]];
    bin_rd       <= bin_mem[bin_next[BW-1:0]];
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      bl  <= '0;
      al  <= '0;
      bin <= '0;
    end else begin
      bl  <= bl_next;
      al  <= al_next;
      bin <= bin_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mid    <= req.mid_price;
        spread <= req.median_spread;
        vol    <= req.day_volume;
        tb     <= '0;
        ta     <= '0;
        nbid   <= (int'(req.bid_level_count) > MAX_LEVELS) ? CW'(MAX_LEVELS)
                                                           : CW'(req.bid_level_count);
        nask   <= (int'(req.ask_level_count) > MAX_LEVELS) ? CW'(MAX_LEVELS)
                                                           : CW'(req.ask_level_count);
        nbins  <= (int'(bins_in_use) > MAX_BINS) ? BCW'(MAX_BINS) : BCW'(bins_in_use);
      end
      ST_MUL: hw <= 40'(bin_rd) * 40'(spread);
      ST_LIM: begin
        blim <= $signed({2'b00, mid, 8'd0}) - $signed({2'b00, hw});
        alim <= $signed({2'b00, mid, 8'd0}) + $signed({2'b00, hw});
      end
      ST_WALK: begin
        if (bid_go) tb <= tb + SW'(bid_size_rd);
        if (ask_go) ta <= ta + SW'(ask_size_rd);
        // load the divider for the imbalance, or post a zero result
        dq   <= DVW'({tdiff, 15'd0}) + DVW'(tsum >> 1);
        dvs  <= DW'(tsum);
        rem  <= '0;
        dcnt <= '0;
        res.imbalance          <= '0;
        res.weighted_imbalance <= '0;
        res.imbalance_valid    <= 1'b0;
        res.weighted_valid     <= 1'b0;
      end
      ST_DIV_A, ST_DIV_B: begin
        // one restoring step per cycle
        rem  <= dfit ? DW'(dtrial - {1'b0, dvs}) : dtrial[DW-1:0];
        dq   <= {dq[DVW-2:0], dfit};
        dcnt <= dcnt + DCW'(1);
      end
      ST_IMB: begin
        if (tb >= ta) imb <= (q_abs[15:0] == 16'h8000) ? 16'sh7FFF : $signed(q_abs[15:0]);
        else          imb <= -$signed(q_abs[15:0]);
        res.imbalance_valid <= 1'b1;
        res.imbalance <= (tb >= ta) ?
          ((q_abs[15:0] == 16'h8000) ? 16'sh7FFF : $signed(q_abs[15:0])) :
          -$signed(q_abs[15:0]);
      end
      ST_WMUL: begin
        // load the divider for the weighted result
        dq   <= DVW'({prod, 1'b0}) + DVW'(vol >> 1);
        dvs  <= DW'(vol);
        rem  <= '0;
        dcnt <= '0;
      end
      default: ;
    endcase
    if (state == ST_WSAT) begin
      res.weighted_valid <= 1'b1;
      if (!imb[15]) res.weighted_imbalance <=
        (q_abs > DVW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q_abs[31:0]);
      else res.weighted_imbalance <=
        (q_abs > DVW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : -$signed(q_abs[31:0]);
    end
    if (state == ST_LIM) begin
      res.bin_number  <= 4'(bin);
      res.last_of_run <= last_bin;
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_book_depth_imbalance.sv -----
// Self-checking testbench for book_depth_imbalance: drives request, result and
// config channels, predicts every band result and compares. Uses bdi_pkg.
`timescale 1ns / 1ps
module tb_book_depth_imbalance;
  import bdi_pkg::*;

  localparam int NLEV      = MAX_LEVELS_DEF;
  localparam int NBIN      = MAX_BINS_DEF;
  localparam int LIMIT     = 3000000;
  localparam int SETTLE    = 300;
  localparam int N_RANDOM  = 18;

  typedef struct packed {
    req_type_t   kind;
    logic [4:0]  idx;
    logic [23:0] price;
    logic [23:0] size;
    logic [15:0] mult;
    logic [5:0]  nbid;
    logic [5:0]  nask;
    logic [31:0] mid;
    logic [23:0] spread;
    logic [31:0] vol;
  } book_word_t;

  typedef struct packed {
    logic [3:0]         bin;
    logic signed [15:0] imb;
    logic signed [31:0] wimb;
    logic               iv;
    logic               wv;
    logic               last;
  } band_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdi_req_if req ();
  bdi_res_if res ();
  bdi_cfg_if cfg ();

  book_depth_imbalance u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .res (res.source),
    .cfg (cfg.sink)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow book state
  logic [23:0] bid_px [NLEV];
  logic [23:0] bid_sz [NLEV];
  logic [23:0] ask_px [NLEV];
  logic [23:0] ask_sz [NLEV];
  logic [15:0] band_mult [NBIN];
  logic [4:0]  bands_reg;

  book_word_t pending_q [$];
  band_word_t band_q [$];

  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  bit req_taken = 0;
  int base_px = 100000;
  int step_px = 4;

  // round half away from zero, d > 0
  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // apply one accepted word to the shadow state, queue its band results
  function automatic void predict_bands(book_word_t w);
    int nb, na, nbins, bl, al;
    longint tb, ta, hw, blim, alim, imb, wimb, big;
    band_word_t r;
    bl = 0; al = 0; tb = 0; ta = 0;
    case (w.kind)
      REQ_BID: begin
        bid_px[w.idx] = w.price;
        bid_sz[w.idx] = w.size;
      end
      REQ_ASK: begin
        ask_px[w.idx] = w.price;
        ask_sz[w.idx] = w.size;
      end
      REQ_BIN: begin
        if (w.idx < NBIN) band_mult[w.idx[3:0]] = w.mult;
      end
      default: begin
        nb = (w.nbid > NLEV) ? NLEV : w.nbid;
        na = (w.nask > NLEV) ? NLEV : w.nask;
        nbins = (bands_reg > NBIN) ? NBIN : bands_reg;
        for (int b = 0; b < nbins; b++) begin
          hw = longint'(band_mult[b]) * longint'(w.spread);
          blim = longint'(w.mid) * 256 - hw;
          alim = longint'(w.mid) * 256 + hw;
          while (bl < nb && longint'(bid_px[bl]) * 65536 >= blim) begin
            tb += bid_sz[bl];
            bl++;
          end
          while (al < na && longint'(ask_px[al]) * 65536 <= alim) begin
            ta += ask_sz[al];
            al++;
          end
          imb = 0; wimb = 0;
          r.iv = (tb + ta) != 0;
          r.wv = r.iv && (w.vol != 0);
          if (r.iv) begin
            imb = round_div((tb - ta) * 32768, tb + ta);
            if (imb > 32767) imb = 32767;
            if (imb < -32768) imb = -32768;
          end
          if (r.wv) begin
            big = (tb > ta) ? tb : ta;
            wimb = round_div(imb * big * 2, longint'(w.vol));
            if (wimb > 64'sd2147483647) wimb = 64'sd2147483647;
            if (wimb < -64'sd2147483648) wimb = -64'sd2147483648;
          end
          r.bin = b[3:0];
          r.imb = imb[15:0];
          r.wimb = wimb[31:0];
          r.last = (b + 1 == nbins);
          band_q.push_back(r);
        end
      end
    endcase
  endfunction

  // accept tracking, prediction, result check, cycle limit
  always @(posedge clk) begin
    book_word_t w;
    band_word_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    req_taken = req.valid && req.ready;
    if (req_taken) begin
      w.kind = req_type_t'(req.req_type);
      w.idx = req.entry_index;
      w.price = req.level_price;
      w.size = req.level_size;
      w.mult = req.bin_multiplier;
      w.nbid = req.bid_level_count;
      w.nask = req.ask_level_count;
      w.mid = req.mid_price;
      w.spread = req.median_spread;
      w.vol = req.day_volume;
      predict_bands(w);
    end
    if (cfg.valid && cfg.ready) bands_reg = cfg.bins_in_use;
    if (res.valid && res.ready) begin
      if (band_q.size() == 0) begin
        $error("unexpected result word, bin_number %0d", res.bin_number);
        errors++;
      end else begin
        e = band_q.pop_front();
        if (res.bin_number !== e.bin) begin
          $error("bin_number exp %0d got %0d", e.bin, res.bin_number); errors++;
        end
        if (res.imbalance !== e.imb) begin
          $error("imbalance exp %0d got %0d", e.imb, res.imbalance); errors++;
        end
        if (res.weighted_imbalance !== e.wimb) begin
          $error("weighted_imbalance exp %0d got %0d", e.wimb, res.weighted_imbalance);
          errors++;
        end
        if (res.imbalance_valid !== e.iv) begin
          $error("imbalance_valid exp %0d got %0d", e.iv, res.imbalance_valid); errors++;
        end
        if (res.weighted_valid !== e.wv) begin
          $error("weighted_valid exp %0d got %0d", e.wv, res.weighted_valid); errors++;
        end
        if (res.last_of_run !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, res.last_of_run); errors++;
        end
      end
    end
  end

  // request driver: holds a word until taken, idles at random
  always @(negedge clk) begin
    book_word_t w;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        w = pending_q.pop_front();
        req.valid <= 1'b1;
        req.req_type <= w.kind;
        req.entry_index <= w.idx;
        req.level_price <= w.price;
        req.level_size <= w.size;
        req.bin_multiplier <= w.mult;
        req.bid_level_count <= w.nbid;
        req.ask_level_count <= w.nask;
        req.mid_price <= w.mid;
        req.median_spread <= w.spread;
        req.day_volume <= w.vol;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_BID;
    req.entry_index = '0;
    req.level_price = '0;
    req.level_size = '0;
    req.bin_multiplier = '0;
    req.bid_level_count = '0;
    req.ask_level_count = '0;
    req.mid_price = '0;
    req.median_spread = '0;
    req.day_volume = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.bins_in_use = '0;
    bands_reg = '0;
  end

  task automatic send_level(req_type_t k, int i, int px, int sz);
    book_word_t w;
    w = '0;
    w.kind = k; w.idx = 5'(i); w.price = 24'(px); w.size = 24'(sz);
    pending_q.push_back(w);
  endtask

  task automatic send_band(int i, int m);
    book_word_t w;
    w = '0;
    w.kind = REQ_BIN; w.idx = 5'(i); w.mult = 16'(m);
    pending_q.push_back(w);
  endtask

  task automatic send_compute(int nb, int na, logic [31:0] mid, int spr, logic [31:0] vol);
    book_word_t w;
    w = '0;
    w.kind = REQ_COMPUTE; w.nbid = 6'(nb); w.nask = 6'(na);
    w.mid = mid; w.spread = 24'(spr); w.vol = vol;
    pending_q.push_back(w);
  endtask

  // wait until every word is taken and every band result is in
  task automatic drain();
    while (pending_q.size() > 0 || req.valid || band_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bands(logic [4:0] n);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.bins_in_use <= n;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // ladder of levels around base_px, best first, and a multiplier for every band
  task automatic fill_book();
    for (int i = 0; i < NLEV; i++) begin
      send_level(REQ_BID, i, base_px - i * step_px, $urandom_range(5000, 1));
      send_level(REQ_ASK, i, base_px + step_px + i * step_px, $urandom_range(5000, 1));
    end
    for (int b = 0; b < NBIN; b++) send_band(b, (b + 1) * 96);
  endtask

  task automatic random_word();
    int r, i;
    book_word_t w;
    r = $urandom_range(99);
    i = $urandom_range(NLEV - 1);
    if (r < 30) begin
      if ($urandom_range(1))
        send_level(REQ_BID, i, base_px - i * step_px - $urandom_range(3),
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(100000));
      else
        send_level(REQ_ASK, i, base_px + step_px + i * step_px + $urandom_range(3),
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(100000));
    end else if (r < 45) begin
      send_band($urandom_range(31), $urandom_range(3) == 0 ? $urandom_range(65535)
                                                        : $urandom_range(4096));
    end else if (r < 85) begin
      case ($urandom_range(3))
        0: w.vol = 0;
        1: w.vol = $urandom_range(3);
        default: w.vol = $urandom;
      endcase
      send_compute($urandom_range(40), $urandom_range(40),
                   base_px * 256 + $urandom_range(511), step_px * 256 * $urandom_range(3, 1)
                   + $urandom_range(255), w.vol);
    end else begin
      w.kind = req_type_t'($urandom_range(3));
      w.idx = 5'($urandom); w.price = 24'($urandom); w.size = 24'($urandom);
      w.mult = 16'($urandom);
      w.nbid = 6'($urandom); w.nask = 6'($urandom); w.mid = $urandom;
      w.spread = 24'($urandom);
      w.vol = $urandom;
      pending_q.push_back(w);
    end
  endtask

  initial begin
    int stall_pct [4];
    int idle_pct [4];
    logic [4:0] band_set [4];
    idle_pct = '{0, 76, 0, 20};
    stall_pct = '{0, 0, 76, 20};
    band_set = '{5'd31, 5'd1, 5'd16, 5'd0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every store entry written before any read
    write_bands(5'd16);
    fill_book();
    drain();

    // directed: extremes and corner cases
    send_compute(0, 0, base_px * 256, 1024, 1000);
    send_compute(63, 63, base_px * 256, 1024, 0);
    send_compute(32, 32, base_px * 256, 1024, 1);
    send_compute(32, 32, 0, 24'hFFFFFF, 32'hFFFFFFFF);
    send_compute(32, 32, 32'hFFFFFFFF, 0, 12345);
    send_band(20, 16'hFFFF);
    send_band(31, 16'h1234);
    send_band(0, 0);
    send_band(15, 16'hFFFF);
    send_level(REQ_BID, 0, base_px, 0);
    send_level(REQ_ASK, 0, base_px + step_px, 0);
    send_compute(1, 1, base_px * 256, 1024, 77);
    send_level(REQ_BID, 31, 24'hFFFFFF, 24'hFFFFFF);
    send_level(REQ_ASK, 31, 0, 24'hFFFFFF);
    send_compute(32, 32, base_px * 256, 24'hFFFFFF, 1);
    send_compute(32, 0, base_px * 256, 4096, 3);
    send_compute(0, 32, base_px * 256, 4096, 3);
    drain();
    write_bands(5'd0);
    send_compute(32, 32, base_px * 256, 1024, 500);
    drain();

    // random phases, each with its own band count and idle and stall pattern
    for (int p = 0; p < 4; p++) begin
      write_bands(band_set[p]);
      send_idle = idle_pct[p];
      recv_stall = stall_pct[p];
      if (p == 2) hold_off = 1500;
      for (int n = 0; n < N_RANDOM; n++) random_word();
      drain();
    end
    write_bands(5'd16);
    send_idle = 0;
    recv_stall = 0;
    for (int n = 0; n < 10; n++) random_word();
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- book_depth_imbalance.f -----
hdl/bdi_pkg.sv
hdl/bdi_channels.sv
hdl/book_depth_imbalance.sv
tb/tb_book_depth_imbalance.sv
